// ===== src/interval_range_value_table_macros.svh =====
// assertion macros for the interval range value table
`ifndef INTERVAL_RANGE_VALUE_TABLE_MACROS_SVH
`define INTERVAL_RANGE_VALUE_TABLE_MACROS_SVH

// same-cycle implication on clk, held off during reset
`define IVT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication on clk, held off during reset
`define IVT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/ivt_pkg.sv =====
// shared types and codes for the interval range value table
package ivt_pkg;

    localparam int KEY_W   = 32;
    localparam int VAL_W   = 8;
    localparam int STAT_W  = 2;

    localparam logic       MODE_ASSIGN = 1'b0;
    localparam logic       MODE_LOOKUP = 1'b1;

    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic        [VAL_W-1:0] value;
    } entry_t;

endpackage

// ===== src/ivt_table_mem.sv =====
// double-banked boundary table memory, one write and one registered read per cycle
module ivt_table_mem #(
    parameter int DEPTH = 16
) (
    input  logic                          clk,
    input  logic                          rd_bank,
    input  logic [$clog2(DEPTH)-1:0]      rd_addr,
    output ivt_pkg::entry_t               rd_entry,
    input  logic                          wr_en,
    input  logic                          wr_bank,
    input  logic [$clog2(DEPTH)-1:0]      wr_addr,
    input  ivt_pkg::entry_t               wr_entry
);
    import ivt_pkg::*;

    entry_t mem [2][DEPTH];
    entry_t rd_entry_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_bank][wr_addr] <= wr_entry;
        end
        rd_entry_reg <= mem[rd_bank][rd_addr];
    end

    assign rd_entry = rd_entry_reg;

endmodule

// ===== src/ivt_seq.sv =====
// sequencer: scans the active bank, rebuilds into the other bank on assign
module ivt_seq #(
    parameter int DEPTH = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              mode,
    input  logic signed [ivt_pkg::KEY_W-1:0]  range_begin,
    input  logic signed [ivt_pkg::KEY_W-1:0]  range_end,
    input  logic        [ivt_pkg::VAL_W-1:0]  new_value,
    input  logic signed [ivt_pkg::KEY_W-1:0]  query_key,
    input  logic                              cfg_we,
    input  logic        [ivt_pkg::VAL_W-1:0]  cfg_wdata,
    output logic                              done,
    output logic        [ivt_pkg::VAL_W-1:0]  read_value,
    output logic        [ivt_pkg::STAT_W-1:0] status,
    output logic                              rd_bank,
    output logic [$clog2(DEPTH)-1:0]          rd_addr,
    input  ivt_pkg::entry_t                   rd_entry,
    output logic                              wr_en,
    output logic                              wr_bank,
    output logic [$clog2(DEPTH)-1:0]          wr_addr,
    output ivt_pkg::entry_t                   wr_entry
);
    import ivt_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int NW = $clog2(DEPTH + 3);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    logic                    state_reg,   state_next;
    logic                    mode_reg,    mode_next;
    logic signed [KEY_W-1:0] rb_reg,      rb_next;
    logic signed [KEY_W-1:0] thr_reg,     thr_next;
    logic        [VAL_W-1:0] nv_reg,      nv_next;
    logic        [VAL_W-1:0] v_reg,       v_next;
    logic        [CW-1:0]    i_reg,       i_next;
    logic        [NW-1:0]    wn_reg,      wn_next;
    logic                    rb_done_reg, rb_done_next;
    logic                    re_done_reg, re_done_next;
    logic                    bank_reg,    bank_next;
    logic        [CW-1:0]    count_reg,   count_next;
    logic        [VAL_W-1:0] default_reg, default_next;
    logic                    done_reg,    done_next;
    logic        [VAL_W-1:0] rv_reg,      rv_next;
    logic       [STAT_W-1:0] status_reg,  status_next;

    logic at_end;
    logic signed [KEY_W-1:0] cur_key;

    assign at_end  = (i_reg == count_reg);
    assign cur_key = rd_entry.key;

    always_comb
    begin
        state_next   = state_reg;
        mode_next    = mode_reg;
        rb_next      = rb_reg;
        thr_next     = thr_reg;
        nv_next      = nv_reg;
        v_next       = v_reg;
        i_next       = i_reg;
        wn_next      = wn_reg;
        rb_done_next = rb_done_reg;
        re_done_next = re_done_reg;
        bank_next    = bank_reg;
        count_next   = count_reg;
        default_next = cfg_we ? cfg_wdata : default_reg;
        done_next    = 1'b0;
        rv_next      = rv_reg;
        status_next  = status_reg;
        wr_en        = 1'b0;
        wr_entry     = rd_entry;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    mode_next    = mode;
                    rb_next      = range_begin;
                    thr_next     = (mode == MODE_LOOKUP) ? query_key : range_end;
                    nv_next      = new_value;
                    v_next       = default_reg;
                    i_next       = '0;
                    wn_next      = '0;
                    rb_done_next = 1'b0;
                    re_done_next = 1'b0;
                    if (mode == MODE_ASSIGN && range_begin >= range_end)
                    begin
                        done_next   = 1'b1;
                        rv_next     = '0;
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (mode_reg == MODE_LOOKUP)
                begin
                    if (at_end || cur_key > thr_reg)
                    begin
                        state_next  = S_IDLE;
                        done_next   = 1'b1;
                        rv_next     = v_reg;
                        status_next = ST_DONE;
                    end
                    else
                    begin
                        v_next = rd_entry.value;
                        i_next = i_reg + CW'(1);
                    end
                end
                else if (!rb_done_reg && (at_end || cur_key >= rb_reg))
                begin
                    wr_en          = (wn_reg < DEPTH);
                    wr_entry.key   = rb_reg;
                    wr_entry.value = nv_reg;
                    wn_next        = wn_reg + NW'(1);
                    rb_done_next   = 1'b1;
                end
                else if (!re_done_reg && (at_end || cur_key > thr_reg))
                begin
                    wr_en          = (wn_reg < DEPTH);
                    wr_entry.key   = thr_reg;
                    wr_entry.value = v_reg;
                    wn_next        = wn_reg + NW'(1);
                    re_done_next   = 1'b1;
                end
                else if (at_end)
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                    rv_next    = '0;
                    if (wn_reg > DEPTH)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        status_next = ST_DONE;
                        bank_next   = ~bank_reg;
                        count_next  = wn_reg[CW-1:0];
                    end
                end
                else
                begin
                    if (cur_key <= thr_reg)
                    begin
                        v_next = rd_entry.value;
                    end
                    if (cur_key < rb_reg || cur_key > thr_reg)
                    begin
                        wr_en   = (wn_reg < DEPTH);
                        wn_next = wn_reg + NW'(1);
                    end
                    i_next = i_reg + CW'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            bank_reg    <= 1'b0;
            count_reg   <= '0;
            default_reg <= '0;
            done_reg    <= 1'b0;
            mode_reg    <= MODE_ASSIGN;
            rb_done_reg <= 1'b0;
            re_done_reg <= 1'b0;
            i_reg       <= '0;
            wn_reg      <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            bank_reg    <= bank_next;
            count_reg   <= count_next;
            default_reg <= default_next;
            done_reg    <= done_next;
            mode_reg    <= mode_next;
            rb_done_reg <= rb_done_next;
            re_done_reg <= re_done_next;
            i_reg       <= i_next;
            wn_reg      <= wn_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rb_reg     <= rb_next;
        thr_reg    <= thr_next;
        nv_reg     <= nv_next;
        v_reg      <= v_next;
        rv_reg     <= rv_next;
        status_reg <= status_next;
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign read_value = rv_reg;
    assign status     = status_reg;
    assign rd_bank    = bank_reg;
    assign rd_addr    = (i_next < DEPTH) ? i_next[AW-1:0] : '0;
    assign wr_bank    = ~bank_reg;
    assign wr_addr    = wn_reg[AW-1:0];

endmodule

// ===== src/interval_range_value_table.sv =====
// top level of the interval range value table
//
// usage:
//   an item is taken on a rising edge with start high and busy low; mode 0
//   assigns new_value to keys in [range_begin, range_end), mode 1 looks up
//   query_key. each item gives one result: done is high for one cycle with
//   read_value and status, and the receiver cannot hold it off.
//   the default value is written with cfg_we and cfg_wdata while idle.
// operation:
//   empty-range assign: result in the cycle after the start, busy stays low
//   lookup: the scan stops at the first boundary above the key or at the end
//   assign: scans the table one entry per cycle, pausing to write each new
//   boundary; it reads the live bank and writes the rebuilt bank in turn
//   a new item may be started in the cycle its predecessor's result shows
// reset:
//   rst_n low empties the table (count zero) and clears the default value;
//   no clearing pass runs, the table accepts items right after reset
module interval_range_value_table #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              mode,
    input  logic signed [ivt_pkg::KEY_W-1:0]  range_begin,
    input  logic signed [ivt_pkg::KEY_W-1:0]  range_end,
    input  logic        [ivt_pkg::VAL_W-1:0]  new_value,
    input  logic signed [ivt_pkg::KEY_W-1:0]  query_key,
    input  logic                              cfg_we,
    input  logic        [ivt_pkg::VAL_W-1:0]  cfg_wdata,
    output logic                              done,
    output logic        [ivt_pkg::VAL_W-1:0]  read_value,
    output logic        [ivt_pkg::STAT_W-1:0] status
);
    import ivt_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);

    logic          rd_bank;
    logic [AW-1:0] rd_addr;
    entry_t        rd_entry;
    logic          wr_en;
    logic          wr_bank;
    logic [AW-1:0] wr_addr;
    entry_t        wr_entry;

    ivt_seq #(
        .DEPTH(TABLE_DEPTH)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .mode       (mode),
        .range_begin(range_begin),
        .range_end  (range_end),
        .new_value  (new_value),
        .query_key  (query_key),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .done       (done),
        .read_value (read_value),
        .status     (status),
        .rd_bank    (rd_bank),
        .rd_addr    (rd_addr),
        .rd_entry   (rd_entry),
        .wr_en      (wr_en),
        .wr_bank    (wr_bank),
        .wr_addr    (wr_addr),
        .wr_entry   (wr_entry)
    );

    ivt_table_mem #(
        .DEPTH(TABLE_DEPTH)
    ) u_mem (
        .clk     (clk),
        .rd_bank (rd_bank),
        .rd_addr (rd_addr),
        .rd_entry(rd_entry),
        .wr_en   (wr_en),
        .wr_bank (wr_bank),
        .wr_addr (wr_addr),
        .wr_entry(wr_entry)
    );

`include "interval_range_value_table_macros.svh"

    `IVT_ASSERT_NEXT(a_empty_range, start && !busy && mode == MODE_ASSIGN && range_begin >= range_end, done && status == ST_EMPTY && read_value == '0, "empty range not reported at once")
    `IVT_ASSERT_NEXT(a_lookup_scans, start && !busy && mode == MODE_LOOKUP, busy && !done, "lookup did not enter the scan")
    `IVT_ASSERT_NOW(a_assign_zero, done && status != ST_DONE, read_value == '0 && (status == ST_FULL || status == ST_EMPTY), "refused item carries a value")
    `IVT_ASSERT_NOW(a_write_other_bank, wr_en, wr_bank != rd_bank, "write hit the live bank")

endmodule
